// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/stm_pkg.sv =====
// ----------------------------------------------------------------------------
// stm_pkg
// types, codes and the name key function of the symbol table
// ----------------------------------------------------------------------------
package stm_pkg;

    localparam int DEF_TABLE_ENTRIES = 256;
    localparam int DEF_NAME_BYTES    = 32;

    // key is 31 bytes: three full words and a 7-byte tail
    localparam int KEY_BYTES = 31;
    localparam int KEY_BITS  = 8 * KEY_BYTES;
    localparam int COUNT_W   = 9;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_COUNT  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE
    } state_t;

    typedef logic [KEY_BITS-1:0] key_t;

    typedef struct packed {
        logic [63:0] value;
        logic        defined;
        logic [3:0]  obj;
        logic [15:0] sect;
    } entry_t;

    typedef struct packed {
        op_t         op;
        key_t        key;
        logic [63:0] value;
        logic        defined;
        logic [3:0]  obj;
        logic [15:0] sect;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic               found;
        logic [63:0]        value;
        logic               defined;
        logic [3:0]         obj;
        logic [15:0]        sect;
        logic [COUNT_W-1:0] undef_cnt;
        logic [COUNT_W-1:0] entry_cnt;
    } res_t;

    typedef struct packed {
        logic rd_en;
        logic key_we;
        logic data_we;
    } mem_ctl_t;

    // keep bytes up to the first zero byte and below name_bytes-1
    function automatic key_t make_key(input key_t raw, input int name_bytes);
        key_t kept;
        logic ended;
        kept  = '0;
        ended = 1'b0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (raw[8*b +: 8] == 8'h00 || b >= name_bytes - 1) begin
                ended = 1'b1;
            end
            if (!ended) begin
                kept[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return kept;
    endfunction

endpackage

// ===== rtl/symbol_table_merge.sv =====
// ----------------------------------------------------------------------------
// symbol_table_merge
// keyed linker symbol table with add, lookup, undefined count and clear
// ----------------------------------------------------------------------------
// A symbol table for linking, searched one stored name per cycle. An add or
// lookup item is accepted, then scanned linearly through the entries held
// (each read through the name memory read port, then one key compare), then
// resolved in an update step; a scan stops once the matching entry compares
// equal, and with an empty table it is skipped. Count and clear items go
// from accept straight to the update step. The scan runs through the single
// name memory port with its registered read. The input side is ready only
// in the idle state; the result sits in an output register, so a new item
// can be taken while the last result waits. Entry storage needs no clearing
// pass after reset: entries at or above the entry count are never read, and
// clear only resets the counters.
// ----------------------------------------------------------------------------
module symbol_table_merge #(
    parameter int TABLE_ENTRIES = stm_pkg::DEF_TABLE_ENTRIES,
    parameter int NAME_BYTES    = stm_pkg::DEF_NAME_BYTES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // name_word0, name_word1, name_word2, name_word3, sym_value, is_defined,
    // obj_index, sect_index, zero fill
    input  logic [335:0] s_tdata,
    // op
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, found, out_value, out_defined, out_obj, out_sect,
    // undefined_count, entry_count, zero fill
    output logic [111:0] m_tdata
);
    import stm_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [63:0] name_word0;
    logic [63:0] name_word1;
    logic [63:0] name_word2;
    logic [55:0] name_word3;
    req_t        req;
    logic        seq_ready;
    logic        res_valid;
    res_t        res;
    logic        out_free;
    mem_ctl_t    mem_ctl;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    key_t        wr_key;
    entry_t      wr_data;
    key_t        rd_key;
    entry_t      rd_data;
    logic        m_tvalid_reg;
    res_t        out_reg;

    // unpack the input item and canonicalize the name key
    assign name_word0  = s_tdata[63:0];
    assign name_word1  = s_tdata[127:64];
    assign name_word2  = s_tdata[191:128];
    assign name_word3  = s_tdata[247:192];
    assign req.op      = op_t'(s_tuser);
    assign req.key     = make_key({name_word3, name_word2, name_word1, name_word0},
                                  NAME_BYTES);
    assign req.value   = s_tdata[311:248];
    assign req.defined = s_tdata[312];
    assign req.obj     = s_tdata[316:313];
    assign req.sect    = s_tdata[332:317];

    assign s_tready = seq_ready;

    // result slot is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    stm_seq #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(s_tvalid),
        .req      (req),
        .ready    (seq_ready),
        .out_free (out_free),
        .res_valid(res_valid),
        .res      (res),
        .mem_ctl  (mem_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_data  (wr_data),
        .rd_key   (rd_key),
        .rd_data  (rd_data)
    );

    stm_store #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_store (
        .clk    (clk),
        .ctl    (mem_ctl),
        .rd_addr(rd_addr),
        .wr_addr(wr_addr),
        .wr_key (wr_key),
        .wr_data(wr_data),
        .rd_key (rd_key),
        .rd_data(rd_data)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0,
                       out_reg.entry_cnt,
                       out_reg.undef_cnt,
                       out_reg.sect,
                       out_reg.obj,
                       out_reg.defined,
                       out_reg.value,
                       out_reg.found,
                       out_reg.status};

    // checks on the sequencer and result path
    `include "assert_macros.svh"

    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accept")
    `ASSERT_IMPLIES(a_res_slot_free, res_valid, out_free, "result would overwrite pending item")
    `ASSERT_IMPLIES(a_found_is_ok, m_tvalid_reg && out_reg.found, out_reg.status == ST_OK, "found with error status")
    `ASSERT_IMPLIES(a_full_at_cap, m_tvalid_reg && out_reg.status == ST_FULL, out_reg.entry_cnt == COUNT_W'(TABLE_ENTRIES), "full below capacity")

endmodule

// ===== rtl/stm_store.sv =====
// ----------------------------------------------------------------------------
// stm_store
// name key memory and entry data memory, one write and one read port each
// ----------------------------------------------------------------------------
module stm_store #(
    parameter int TABLE_ENTRIES = stm_pkg::DEF_TABLE_ENTRIES,
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic              clk,
    input  stm_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]     rd_addr,
    input  logic [AW-1:0]     wr_addr,
    input  stm_pkg::key_t     wr_key,
    input  stm_pkg::entry_t   wr_data,
    output stm_pkg::key_t     rd_key,
    output stm_pkg::entry_t   rd_data
);
    import stm_pkg::*;

    key_t   name_mem [TABLE_ENTRIES];
    entry_t data_mem [TABLE_ENTRIES];
    key_t   rd_key_reg;
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.key_we)
        begin
            name_mem[wr_addr] <= wr_key;
        end
        if (ctl.rd_en)
        begin
            rd_key_reg <= name_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.data_we)
        begin
            data_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= data_mem[rd_addr];
        end
    end

    assign rd_key  = rd_key_reg;
    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/stm_seq.sv =====
// ----------------------------------------------------------------------------
// stm_seq
// sequencer: linear key scan through the shared comparator, then update
// ----------------------------------------------------------------------------
module stm_seq #(
    parameter int TABLE_ENTRIES = stm_pkg::DEF_TABLE_ENTRIES,
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  stm_pkg::req_t     req,
    output logic              ready,
    input  logic              out_free,
    output logic              res_valid,
    output stm_pkg::res_t     res,
    output stm_pkg::mem_ctl_t mem_ctl,
    output logic [AW-1:0]     rd_addr,
    output logic [AW-1:0]     wr_addr,
    output stm_pkg::key_t     wr_key,
    output stm_pkg::entry_t   wr_data,
    input  stm_pkg::key_t     rd_key,
    input  stm_pkg::entry_t   rd_data
);
    import stm_pkg::*;

    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    state_t        state_reg, state_next;
    req_t          req_reg, req_next;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] open_reg, open_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic          hit_reg, hit_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    entry_t        hit_data_reg, hit_data_next;
    logic          key_match;
    logic          last_pend;

    // the one shared compare unit
    assign key_match = pend_valid_reg && (rd_key == req_reg.key);
    assign last_pend = pend_valid_reg && ((CW'(pend_idx_reg) + CW'(1)) == used_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            open_reg       <= '0;
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            open_reg       <= open_next;
            scan_idx_reg   <= scan_idx_next;
            pend_valid_reg <= pend_valid_next;
            hit_reg        <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_data_reg <= hit_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        used_next       = used_reg;
        open_next       = open_reg;
        scan_idx_next   = scan_idx_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_data_next   = hit_data_reg;
        mem_ctl         = '0;
        rd_addr         = scan_idx_reg[AW-1:0];
        wr_addr         = used_reg[AW-1:0];
        wr_key          = req_reg.key;
        wr_data.value   = req_reg.value;
        wr_data.defined = req_reg.defined;
        wr_data.obj     = req_reg.obj;
        wr_data.sect    = req_reg.sect;
        res             = '0;
        res_valid       = 1'b0;
        ready           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                ready = 1'b1;
                if (req_valid)
                begin
                    req_next      = req;
                    hit_next      = 1'b0;
                    scan_idx_next = '0;
                    if ((req.op == OP_ADD || req.op == OP_LOOKUP) && used_reg != '0)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RESOLVE;
                    end
                end
            end

            S_SCAN:
            begin
                // one entry read per cycle, compared in the cycle after its read
                if (key_match)
                begin
                    hit_next      = 1'b1;
                    hit_idx_next  = pend_idx_reg;
                    hit_data_next = rd_data;
                    state_next    = S_RESOLVE;
                end
                else if (last_pend)
                begin
                    state_next = S_RESOLVE;
                end
                else if (scan_idx_reg < used_reg)
                begin
                    mem_ctl.rd_en   = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = scan_idx_reg[AW-1:0];
                    scan_idx_next   = scan_idx_reg + CW'(1);
                end
            end

            S_RESOLVE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                    unique case (req_reg.op)
                        OP_ADD:
                        begin
                            if (hit_reg)
                            begin
                                if (hit_data_reg.defined && req_reg.defined)
                                begin
                                    res.status = ST_DUP;
                                end
                                else if (req_reg.defined)
                                begin
                                    mem_ctl.data_we = 1'b1;
                                    wr_addr         = hit_idx_reg;
                                    if (!hit_data_reg.defined && open_reg != '0)
                                    begin
                                        open_next = open_reg - CW'(1);
                                    end
                                end
                            end
                            else if (used_reg >= CW'(TABLE_ENTRIES))
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                mem_ctl.key_we  = 1'b1;
                                mem_ctl.data_we = 1'b1;
                                used_next       = used_reg + CW'(1);
                                if (!req_reg.defined)
                                begin
                                    open_next = open_reg + CW'(1);
                                end
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (hit_reg)
                            begin
                                res.found   = 1'b1;
                                res.value   = hit_data_reg.value;
                                res.defined = hit_data_reg.defined;
                                res.obj     = hit_data_reg.obj;
                                res.sect    = hit_data_reg.sect;
                            end
                        end
                        OP_COUNT:
                        begin
                        end
                        OP_CLEAR:
                        begin
                            used_next = '0;
                            open_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    res.undef_cnt = COUNT_W'(open_next);
                    res.entry_cnt = COUNT_W'(used_next);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
